>>> src/address_region_table_assert.svh
// Assertion macros for the address region table RTL.
// Included by art_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef ADDRESS_REGION_TABLE_ASSERT_SVH
`define ADDRESS_REGION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ART_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never becomes true outside reset.
`define ART_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ART_ASSERT(lbl, clk, rstn, prop, msg)
`define ART_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> src/art_pkg.sv
// Types and constants for the address region table.
// Used by art_ram, art_ctrl and address_region_table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 32;
    localparam int PERM_W = 3;
    localparam int ALIGN_BITS = 12;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_FIND     = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERLAP    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_MISALIGNED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_t;

    // One stored region
    typedef struct packed {
        logic [PERM_W-1:0] perm;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } entry_t;

    // One command as accepted from the input stream
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [PERM_W-1:0] perm;
    } request_t;

    // One result handed to the output register
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] found_base;
        logic [SIZE_W-1:0] found_size;
        logic [PERM_W-1:0] found_perm;
    } result_t;

    // Table memory access
    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } ram_req_t;

endpackage

`default_nettype wire

>>> src/art_ram.sv
// Single-port region table memory with registered read data.
// Depends on art_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module art_ram
    import art_pkg::*;
(
    input  wire logic     aclk,
    input  var  ram_req_t req,
    output entry_t        rdata
);

    entry_t mem [MAX_REGIONS];
    entry_t rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/art_ctrl.sv
// Command sequencer: scans the table memory, keeps valid bits, builds results.
// Depends on art_pkg and address_region_table_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "address_region_table_assert.svh"

module art_ctrl
    import art_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     start,
    input  var  request_t req,
    output logic          idle,
    output logic          res_valid,
    input  wire logic     res_ready,
    output result_t       res,
    output ram_req_t      ram_req,
    input  var  entry_t   ram_rdata
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_REGIONS - 1);

    fsm_t                   state_reg;
    fsm_t                   state_next;
    request_t               req_reg;
    logic [ADDR_W:0]        add_end_reg;
    logic [MAX_REGIONS-1:0] valid_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   issue_done_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic                   overlap_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    entry_t                 found_reg;

    logic            rd_entry_valid;
    logic [ADDR_W:0] entry_end;
    logic            ovl_hit;
    logic            rm_hit;
    logic            find_hit;
    logic            entry_hit;
    logic            misaligned;
    logic            add_ok;
    logic            rm_ok;
    logic            issue;
    logic            finish;

    // Compare the entry that arrived from memory against the held command
    always_comb begin
        rd_entry_valid = valid_reg[rd_idx_reg];
        entry_end = {1'b0, ram_rdata.base} + {1'b0, ram_rdata.size};
        ovl_hit = rd_entry_valid && ({1'b0, req_reg.addr} <= entry_end)
                  && ({1'b0, ram_rdata.base} <= add_end_reg);
        rm_hit = rd_entry_valid && (ram_rdata.base == req_reg.addr);
        find_hit = rd_entry_valid && (req_reg.addr >= ram_rdata.base)
                   && ({1'b0, req_reg.addr} <= entry_end);
        entry_hit = (req_reg.cmd == CMD_REMOVE) ? rm_hit : find_hit;
    end

    // Decide the outcome of the command once the scan is over
    always_comb begin
        misaligned = (req_reg.addr[ALIGN_BITS-1:0] != '0);
        add_ok = (req_reg.cmd == CMD_ADD) && !misaligned && !overlap_reg && free_found_reg;
        rm_ok = (req_reg.cmd == CMD_REMOVE) && hit_reg;
        res = '{status: ST_NOT_FOUND, found_base: '0, found_size: '0, found_perm: '0};
        case (req_reg.cmd)
            CMD_ADD: begin
                if (misaligned) begin
                    res.status = ST_MISALIGNED;
                end else if (overlap_reg) begin
                    res.status = ST_OVERLAP;
                end else if (!free_found_reg) begin
                    res.status = ST_FULL;
                end else begin
                    res.status = ST_OK;
                end
            end
            CMD_REMOVE: begin
                if (hit_reg) begin
                    res.status = ST_OK;
                end
            end
            CMD_FIND: begin
                if (hit_reg) begin
                    res.status = ST_OK;
                    res.found_base = found_reg.base;
                    res.found_size = found_reg.size;
                    res.found_perm = found_reg.perm;
                end
            end
            default: begin
                res.status = ST_NOT_FOUND;
            end
        endcase
    end

    // Next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        idle = 1'b0;
        res_valid = 1'b0;
        issue = 1'b0;
        finish = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                issue = !issue_done_reg;
                if (rd_vld_reg && (rd_idx_reg == IDX_LAST)) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    finish = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Table memory port: reads during the scan, one write when an add lands
    always_comb begin
        ram_req.we = finish && add_ok;
        ram_req.en = issue || ram_req.we;
        ram_req.addr = ram_req.we ? free_idx_reg : idx_reg;
        ram_req.wdata = '{perm: req_reg.perm, size: req_reg.size, base: req_reg.addr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan counters and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            idx_reg <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            rd_vld_reg <= issue;
            rd_idx_reg <= idx_reg;
            if (start && idle) begin
                idx_reg <= '0;
                issue_done_reg <= 1'b0;
            end else if (issue) begin
                if (idx_reg == IDX_LAST) begin
                    issue_done_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (finish && add_ok) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (finish && rm_ok) begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Capture the command and gather matches as entries stream by
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
            overlap_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (start && idle) begin
            hit_reg <= 1'b0;
            overlap_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (ovl_hit) begin
                overlap_reg <= 1'b1;
            end
            if (entry_hit) begin
                hit_reg <= 1'b1;
            end
            if (!rd_entry_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && idle) begin
            req_reg <= req;
            add_end_reg <= {1'b0, req.addr} + {1'b0, req.size};
        end
        if (rd_vld_reg) begin
            if (entry_hit) begin
                hit_idx_reg <= rd_idx_reg;
                found_reg <= ram_rdata;
            end
            if (!rd_entry_valid && !free_found_reg) begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    `ART_NEVER(a_write_outside_finish, aclk, aresetn, ram_req.we && (state_reg != FSM_FINISH), "table write outside finish")
    `ART_ASSERT(a_add_to_free_slot, aclk, aresetn, (finish && add_ok) |-> !valid_reg[free_idx_reg], "add targets an occupied slot")
    `ART_ASSERT(a_remove_valid_slot, aclk, aresetn, (finish && rm_ok) |-> valid_reg[hit_idx_reg], "remove targets an empty slot")
    `ART_ASSERT(a_start_scans, aclk, aresetn, (start && idle) |=> (state_reg == FSM_SCAN) && !rd_vld_reg, "accepted command did not start a scan")
    `ART_NEVER(a_read_data_outside_scan, aclk, aresetn, rd_vld_reg && (state_reg != FSM_SCAN), "read data arrived outside the scan")

endmodule

`default_nettype wire

>>> src/address_region_table.sv
// Address region table: keeps up to MAX_REGIONS regions (base, size, permission)
// in a single-port table memory and answers add, remove and find commands, one
// result per command. Every command, whatever its kind, scans the whole table one
// entry per cycle through the memory's single port. A command holds the block
// from one input transfer to the next: the scan issues one read per entry, the
// read data returns through the memory's output register, the finish state waits
// for room in the output register, commits the change and loads it; then it idles.
// A finished result sits in an output register, so the next command is taken
// while the previous result waits for its transfer. Region ends are inclusive
// and computed in 33 bits; regions that only touch count as overlapping. The
// table starts empty after reset; no clearing pass is needed.
// Depends on art_pkg, art_ram and art_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module address_region_table
    import art_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // cmd[1:0], addr[33:2], size[65:34], perm[68:66]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata   // status[2:0], found_base[34:3], found_size[66:35],
                                       // found_perm[69:67]
);

    request_t  req;
    result_t   res;
    ram_req_t  ram_req;
    entry_t    ram_rdata;
    logic      idle;
    logic      start;
    logic      res_valid;
    logic      res_ready;
    logic      m_tvalid_reg;
    result_t   out_reg;

    // Unpack the input transfer
    assign req.cmd  = cmd_t'(s_tdata[1:0]);
    assign req.addr = s_tdata[33:2];
    assign req.size = s_tdata[65:34];
    assign req.perm = s_tdata[68:66];

    assign s_tready = idle;
    assign start = s_tvalid && idle;

    art_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    art_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register: load a result when the slot is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {2'b00, out_reg.found_perm, out_reg.found_size, out_reg.found_base,
                      out_reg.status};

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for address_region_table: a directed command table, then episodes
// of random command traffic, each result checked against a fixed or shadow-table value.
// Depends on art_pkg and the address_region_table RTL.

module testbench;
    import art_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        EP_FILL,
        EP_DRAIN,
        EP_MIXED,
        EP_LOOKUP
    } episode_t;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    // Shadow copy of the region table
    bit                shadow_valid [MAX_REGIONS];
    logic [ADDR_W-1:0] shadow_base  [MAX_REGIONS];
    logic [SIZE_W-1:0] shadow_size  [MAX_REGIONS];
    logic [PERM_W-1:0] shadow_perm  [MAX_REGIONS];

    result_t   pending_results[$];
    stim_row_t directed_rows[$];

    int          fail_count   = 0;
    int          results_seen = 0;
    int          inputs_taken = 0;
    int          cycle_count  = 0;
    int          cmd_count[4];
    int          status_count[8];
    int          burst_left   = 0;
    logic [11:0] grid_hi      = '0;

    address_region_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Apply one command to the shadow table and return the result it must give
    function automatic result_t region_outcome(request_t r);
        result_t     res;
        logic [32:0] new_end;
        logic [32:0] old_end;
        bit          hit;
        res = '0;
        res.status = ST_NOT_FOUND;
        new_end = {1'b0, r.addr} + {1'b0, r.size};
        hit = 1'b0;
        case (r.cmd)
            CMD_ADD: begin
                if (r.addr[ALIGN_BITS-1:0] != '0) begin
                    res.status = ST_MISALIGNED;
                end else begin
                    // touching ends count as overlap
                    for (int i = 0; i < MAX_REGIONS; i++) begin
                        old_end = {1'b0, shadow_base[i]} + {1'b0, shadow_size[i]};
                        if (shadow_valid[i] && {1'b0, r.addr} <= old_end &&
                            {1'b0, shadow_base[i]} <= new_end)
                            hit = 1'b1;
                    end
                    if (hit) begin
                        res.status = ST_OVERLAP;
                    end else begin
                        res.status = ST_FULL;
                        for (int i = 0; i < MAX_REGIONS && !hit; i++) begin
                            if (!shadow_valid[i]) begin
                                shadow_valid[i] = 1'b1;
                                shadow_base[i]  = r.addr;
                                shadow_size[i]  = r.size;
                                shadow_perm[i]  = r.perm;
                                res.status = ST_OK;
                                hit = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                for (int i = 0; i < MAX_REGIONS && !hit; i++) begin
                    if (shadow_valid[i] && shadow_base[i] == r.addr) begin
                        shadow_valid[i] = 1'b0;
                        res.status = ST_OK;
                        hit = 1'b1;
                    end
                end
            end
            CMD_FIND: begin
                for (int i = 0; i < MAX_REGIONS && !hit; i++) begin
                    old_end = {1'b0, shadow_base[i]} + {1'b0, shadow_size[i]};
                    if (shadow_valid[i] && r.addr >= shadow_base[i] &&
                        {1'b0, r.addr} <= old_end) begin
                        res.status     = ST_OK;
                        res.found_base = shadow_base[i];
                        res.found_size = shadow_size[i];
                        res.found_perm = shadow_perm[i];
                        hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int regions_held();
        int n;
        n = 0;
        foreach (shadow_valid[i])
            if (shadow_valid[i]) n++;
        return n;
    endfunction

    // Directed row whose result comes from the shadow table
    task automatic plan_row(input cmd_t c, input logic [31:0] a, input logic [31:0] s,
                            input logic [2:0] p);
        stim_row_t row;
        row.req   = '{cmd: c, addr: a, size: s, perm: p};
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    // Directed row with its result written out
    task automatic plan_row_fixed(input cmd_t c, input logic [31:0] a, input logic [31:0] s,
                                  input logic [2:0] p, input status_t st,
                                  input logic [31:0] fb, input logic [31:0] fs,
                                  input logic [2:0] fp);
        stim_row_t row;
        row.req   = '{cmd: c, addr: a, size: s, perm: p};
        row.typed = 1'b1;
        row.want  = '{status: st, found_base: fb, found_size: fs, found_perm: fp};
        directed_rows.push_back(row);
    endtask

    // Draw one random command; the episode sets the mix
    function automatic request_t random_request(episode_t ep);
        request_t    r;
        int          idx_list[$];
        int          pick;
        int          k;
        logic [32:0] span;
        logic [32:0] sum;
        r.cmd  = CMD_FIND;
        r.addr = $urandom;
        r.size = $urandom;
        r.perm = 3'($urandom);
        for (int i = 0; i < MAX_REGIONS; i++)
            if (shadow_valid[i]) idx_list.push_back(i);
        k = (idx_list.size() != 0) ? idx_list[$urandom_range(0, idx_list.size() - 1)] : -1;
        case (ep)
            EP_FILL:   pick = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 7);
            EP_DRAIN:  pick = ($urandom_range(0, 4) != 0) ? 4 : 5;
            EP_LOOKUP: pick = ($urandom_range(0, 9) < 7) ? 6 : 7;
            default:   pick = $urandom_range(0, 8);
        endcase
        case (pick)
            0: begin
                // small region inside the current grid window
                r.cmd  = CMD_ADD;
                r.addr = {grid_hi, 8'($urandom_range(0, 255)), 12'h000};
                r.size = $urandom_range(0, 32'h2FFF);
            end
            1: begin
                r.cmd  = CMD_ADD;
                r.addr = $urandom & 32'hFFFF_F000;
            end
            2: begin
                r.cmd  = CMD_ADD;
                r.addr = {20'($urandom), 12'($urandom_range(1, 4095))};
            end
            3: begin
                // same base as a stored region when one exists, so it must overlap
                r.cmd  = CMD_ADD;
                r.addr = (k >= 0) ? shadow_base[k] : ($urandom & 32'hFFFF_F000);
                r.size = $urandom_range(0, 32'hFFFF);
            end
            4: begin
                r.cmd = CMD_REMOVE;
                if (k >= 0) r.addr = shadow_base[k];
            end
            5: begin
                r.cmd = CMD_REMOVE;
                if (k >= 0 && $urandom_range(0, 1) == 1)
                    r.addr = shadow_base[k] + $urandom_range(1, 32'h1000);
            end
            6: begin
                r.cmd = CMD_FIND;
                if (k >= 0) begin
                    case ($urandom_range(0, 3))
                        0: sum = {1'b0, shadow_base[k]};
                        1: sum = {1'b0, shadow_base[k]} + {1'b0, shadow_size[k]};
                        2: begin
                            span = {1'b0, shadow_size[k]} + 33'd1;
                            sum  = {1'b0, shadow_base[k]} + ($urandom % span);
                        end
                        default: sum = {1'b0, shadow_base[k]} + {1'b0, shadow_size[k]} + 33'd1;
                    endcase
                    r.addr = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            7: r.cmd = CMD_FIND;
            default: r.cmd = CMD_RESERVED;
        endcase
        return r;
    endfunction

    // Queue the expected result, then transfer the command; bursts and gaps follow
    task automatic issue(input request_t r, input bit typed, input result_t want);
        result_t predicted;
        int      gap;
        predicted = region_outcome(r);
        cmd_count[r.cmd]++;
        status_count[predicted.status]++;
        pending_results.push_back(typed ? want : predicted);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.perm, r.size, r.addr, r.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stimulus: reset, directed rows, random episodes, drain
    initial begin : stimulus
        episode_t ep;
        int       ep_len;
        int       rand_done;
        int       overflow;
        request_t r;
        result_t  blank;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        blank = '0;

        plan_row_fixed(CMD_FIND,     32'h0000_0000, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_REMOVE,   32'h0000_0000, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'h0000_0001, 32'h0000_0010, 3'd1, ST_MISALIGNED, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, ST_MISALIGNED, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'h0000_0800, 32'h0000_0000, 3'd2, ST_MISALIGNED, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'h0000_0000, 32'h0000_0000, 3'd0, ST_OK, 0, 0, 0);
        plan_row_fixed(CMD_FIND,     32'h0000_0000, 32'hFFFF_FFFF, 3'd7, ST_OK, 0, 0, 0);
        plan_row_fixed(CMD_FIND,     32'h0000_0001, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'h0000_1000, 32'h0000_0FFF, 3'd7, ST_OK, 0, 0, 0);
        plan_row_fixed(CMD_ADD,      32'h0000_2000, 32'h0000_1000, 3'd5, ST_OK, 0, 0, 0);
        // touches the end of the previous region
        plan_row_fixed(CMD_ADD,      32'h0000_3000, 32'h0000_0000, 3'd2, ST_OVERLAP, 0, 0, 0);
        // end lands beyond 32 bits
        plan_row_fixed(CMD_ADD,      32'hFFFF_F000, 32'hFFFF_FFFF, 3'd3, ST_OK, 0, 0, 0);
        plan_row_fixed(CMD_FIND,     32'hFFFF_FFFF, 32'h0000_0000, 3'd0, ST_OK,
                       32'hFFFF_F000, 32'hFFFF_FFFF, 3'd3);
        plan_row(CMD_ADD,            32'hFFFF_E000, 32'h0000_0FFF, 3'd6);
        plan_row_fixed(CMD_ADD,      32'h0000_4000, 32'hFFFF_FFFF, 3'd1, ST_OVERLAP, 0, 0, 0);
        plan_row(CMD_FIND,           32'h0000_3000, 32'h0000_0000, 3'd0);
        plan_row_fixed(CMD_FIND,     32'h0000_3001, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row(CMD_FIND,           32'h0000_1FFF, 32'h1234_5678, 3'd4);
        plan_row_fixed(CMD_REMOVE,   32'h0000_1000, 32'h0000_0000, 3'd0, ST_OK, 0, 0, 0);
        plan_row_fixed(CMD_REMOVE,   32'h0000_1000, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_FIND,     32'h0000_1800, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row_fixed(CMD_REMOVE,   32'h0000_2001, 32'h0000_0000, 3'd0, ST_NOT_FOUND, 0, 0, 0);
        plan_row(CMD_RESERVED,       32'h0000_2000, 32'h0000_1000, 3'd5);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random episodes, starting with a fill so the full table is reached early
        rand_done = 0;
        ep = EP_FILL;
        while (rand_done < RANDOM_ITEMS) begin
            grid_hi  = 12'($urandom);
            overflow = 0;
            case (ep)
                EP_FILL:  ep_len = 40;
                EP_DRAIN: ep_len = regions_held() + 3;
                default:  ep_len = $urandom_range(10, 30);
            endcase
            for (int n = 0; n < ep_len && rand_done < RANDOM_ITEMS && overflow < 3; n++) begin
                r = random_request(ep);
                if (ep == EP_FILL && r.cmd == CMD_ADD && regions_held() == MAX_REGIONS)
                    overflow++;
                issue(r, 1'b0, blank);
                rand_done++;
            end
            ep = episode_t'($urandom_range(0, 3));
        end

        // Drain outstanding results, then let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d commands: add %0d, remove %0d, find %0d, reserved %0d.",
                 results_seen, inputs_taken, cmd_count[CMD_ADD], cmd_count[CMD_REMOVE],
                 cmd_count[CMD_FIND], cmd_count[CMD_RESERVED]);
        $display("Outcomes ok %0d, overlap %0d, full %0d, not found %0d, misaligned %0d.",
                 status_count[ST_OK], status_count[ST_OVERLAP], status_count[ST_FULL],
                 status_count[ST_NOT_FOUND], status_count[ST_MISALIGNED]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: random stall segments, with one long hold-off once traffic is flowing
    initial begin : receiver
        int  seg_len;
        int  mode;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && inputs_taken >= 40) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            seg_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Count input transfers
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            inputs_taken <= inputs_taken + 1;
    end

    // Compare each output transfer with the oldest pending result
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = status_t'(m_tdata[2:0]);
            got.found_base = m_tdata[34:3];
            got.found_size = m_tdata[66:35];
            got.found_perm = m_tdata[69:67];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d", got.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.found_base !== want.found_base) begin
                    $error("found_base: expected %h, actual %h", want.found_base, got.found_base);
                    fail_count++;
                end
                if (got.found_size !== want.found_size) begin
                    $error("found_size: expected %h, actual %h", want.found_size, got.found_size);
                    fail_count++;
                end
                if (got.found_perm !== want.found_perm) begin
                    $error("found_perm: expected %0d, actual %0d", want.found_perm, got.found_perm);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

>>> address_region_table.f
+incdir+src
src/art_pkg.sv
src/art_ram.sv
src/art_ctrl.sv
src/address_region_table.sv
sim/testbench.sv
